[hw/rtl/alarm_slot_table_core_defines.svh]
// Assertion macros shared by the alarm slot table RTL.
`ifndef ALARM_SLOT_TABLE_CORE_DEFINES_SVH
`define ALARM_SLOT_TABLE_CORE_DEFINES_SVH

// Implication checked on the same edge, switched off while reset is held.
`define AST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with the consequent checked after the antecedent (non-overlapping), live during reset as well.
`define AST_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ast_pkg.sv]
// Types and constants shared by the alarm slot table modules.
`default_nettype none

package ast_pkg;

    // Command codes carried by an input word; code 3 is unused.
    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_DEL   = 2'd1,
        CMD_CHECK = 2'd2
    } t_cmd;

    // Status codes carried by a result word.
    typedef enum logic [2:0] {
        ST_ADDED        = 3'd0,
        ST_FULL         = 3'd1,
        ST_DELETED      = 3'd2,
        ST_ALREADY_FREE = 3'd3,
        ST_BAD_INDEX    = 3'd4,
        ST_FIRED        = 3'd5,
        ST_NO_MATCH     = 3'd6
    } t_status;

    // Job kinds decided by the front end.
    typedef enum logic [2:0] {
        JOB_ADD,
        JOB_DEL,
        JOB_DEL_BAD,
        JOB_CHECK,
        JOB_NOP
    } t_job_kind;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_ADD,
        ENG_CHECK,
        ENG_DONE
    } t_eng_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] time_seconds;
        logic [3:0]  slot_index;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot_used;
        logic       alarm_fired;
    } t_out_word;

    typedef struct packed {
        t_job_kind   kind;
        logic [31:0] time_seconds;
        logic [3:0]  slot_index;
    } t_job;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 32;

endpackage

`default_nettype wire

[hw/rtl/ast_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ast_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                          i_wr_data,
    input  wire logic                                      i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hw/rtl/ast_front.sv]
// Front end: registers incoming command words and classifies them into jobs.
`default_nettype none

module ast_front #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire ast_pkg::t_in_word i_in_word,
    output logic                  o_push_valid,
    input  wire logic             i_push_ready,
    output ast_pkg::t_job         o_job
);

    logic              r_full;
    logic              n_full;
    ast_pkg::t_in_word r_word;
    logic              w_push;

    assign w_push     = r_full && i_push_ready;
    assign o_in_ready = !r_full || i_push_ready;

    // Holding register for one command word.
    always_comb begin
        n_full = r_full;
        if (i_in_valid && o_in_ready) begin
            n_full = 1'b1;
        end else if (w_push) begin
            n_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
        if (i_in_valid && o_in_ready) begin
            r_word <= i_in_word;
        end
    end

    // Decode the command and settle index range checks before queueing.
    always_comb begin
        o_job.time_seconds = r_word.time_seconds;
        o_job.slot_index   = r_word.slot_index;
        unique case (r_word.command)
            ast_pkg::CMD_ADD: begin
                o_job.kind = ast_pkg::JOB_ADD;
            end
            ast_pkg::CMD_DEL: begin
                if (int'(r_word.slot_index) >= SLOT_COUNT) begin
                    o_job.kind = ast_pkg::JOB_DEL_BAD;
                end else begin
                    o_job.kind = ast_pkg::JOB_DEL;
                end
            end
            ast_pkg::CMD_CHECK: begin
                o_job.kind = ast_pkg::JOB_CHECK;
            end
            default: begin
                o_job.kind = ast_pkg::JOB_NOP;
            end
        endcase
    end

    assign o_push_valid = r_full;

endmodule

`default_nettype wire

[hw/rtl/ast_queue.sv]
// Short job queue between the front end and the back-end sequencer.
`default_nettype none

module ast_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire ast_pkg::t_job i_push_job,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output ast_pkg::t_job      o_pop_job
);

    ast_pkg::t_job                r_mem [ast_pkg::QUEUE_DEPTH];
    logic [ast_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [ast_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [ast_pkg::QCNT_W-1:0]   r_count;
    logic [ast_pkg::QCNT_W-1:0]   n_count;
    logic                         w_push;
    logic                         w_pop;

    assign o_push_ready = (r_count != ast_pkg::QCNT_W'(ast_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + ast_pkg::QCNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - ast_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + ast_pkg::QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + ast_pkg::QPTR_W'(1);
            end
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ast_engine.sv]
// Back-end sequencer: owns the slot table and scans it one slot per cycle.
`default_nettype none

module ast_engine #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    output logic               o_job_ready,
    input  wire ast_pkg::t_job i_job,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ast_pkg::t_out_word o_out_word
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOT_COUNT - 1);

    ast_pkg::t_eng_state r_state;
    ast_pkg::t_eng_state n_state;
    ast_pkg::t_job       r_job;
    ast_pkg::t_job       n_job;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    n_idx;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic [IDX_W-1:0]    n_cmp_idx;
    logic                r_pend;
    logic                n_pend;
    logic [SLOT_COUNT-1:0] r_slot_valid;
    logic [SLOT_COUNT-1:0] n_slot_valid;
    ast_pkg::t_out_word  r_res;
    ast_pkg::t_out_word  n_res;
    logic                r_out_valid;
    logic                n_out_valid;
    ast_pkg::t_out_word  r_out_word;
    ast_pkg::t_out_word  n_out_word;

    logic                       w_wr_en;
    logic                       w_rd_en;
    logic [ast_pkg::TIME_W-1:0] w_rd_data;
    logic [IDX_W-1:0]           w_del_idx;
    logic                       w_hit;
    logic                       w_out_free;

    // Alarm times live in RAM; only valid slots are ever compared.
    ast_ram #(
        .WIDTH (ast_pkg::TIME_W),
        .DEPTH (SLOT_COUNT)
    ) u_time_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (r_job.time_seconds),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    // Delete indexes are known to be in range once classified as such.
    assign w_del_idx   = IDX_W'(i_job.slot_index);
    assign w_hit       = r_pend && r_slot_valid[r_cmp_idx]
                         && (w_rd_data == r_job.time_seconds);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_job_ready = (r_state == ast_pkg::ENG_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ast_pkg::ENG_IDLE: begin
                if (i_job_valid) begin
                    unique case (i_job.kind)
                        ast_pkg::JOB_ADD:   n_state = ast_pkg::ENG_ADD;
                        ast_pkg::JOB_CHECK: n_state = ast_pkg::ENG_CHECK;
                        default:            n_state = ast_pkg::ENG_DONE;
                    endcase
                end
            end
            ast_pkg::ENG_ADD: begin
                if (!r_slot_valid[r_idx] || (r_idx == LAST)) begin
                    n_state = ast_pkg::ENG_DONE;
                end
            end
            ast_pkg::ENG_CHECK: begin
                if (w_hit || (r_pend && (r_cmp_idx == LAST))) begin
                    n_state = ast_pkg::ENG_DONE;
                end
            end
            ast_pkg::ENG_DONE: begin
                if (w_out_free) begin
                    n_state = ast_pkg::ENG_IDLE;
                end
            end
            default: begin
                n_state = ast_pkg::ENG_IDLE;
            end
        endcase
    end

    // Datapath, table updates and result word.
    always_comb begin
        n_job        = r_job;
        n_idx        = r_idx;
        n_cmp_idx    = r_cmp_idx;
        n_pend       = r_pend;
        n_slot_valid = r_slot_valid;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_word   = r_out_word;
        w_wr_en      = 1'b0;
        w_rd_en      = 1'b0;
        unique case (r_state)
            ast_pkg::ENG_IDLE: begin
                if (i_job_valid) begin
                    n_job  = i_job;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_res  = '{status: ast_pkg::ST_NO_MATCH, slot_used: 4'd0,
                               alarm_fired: 1'b0};
                    unique case (i_job.kind)
                        ast_pkg::JOB_DEL_BAD: begin
                            n_res.status    = ast_pkg::ST_BAD_INDEX;
                            n_res.slot_used = i_job.slot_index;
                        end
                        ast_pkg::JOB_DEL: begin
                            n_res.slot_used = i_job.slot_index;
                            if (r_slot_valid[w_del_idx]) begin
                                n_res.status            = ast_pkg::ST_DELETED;
                                n_slot_valid[w_del_idx] = 1'b0;
                            end else begin
                                n_res.status = ast_pkg::ST_ALREADY_FREE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ast_pkg::ENG_ADD: begin
                // Lowest free slot takes the new time.
                if (!r_slot_valid[r_idx]) begin
                    w_wr_en             = 1'b1;
                    n_slot_valid[r_idx] = 1'b1;
                    n_res.status        = ast_pkg::ST_ADDED;
                    n_res.slot_used     = 4'(r_idx);
                end else if (r_idx == LAST) begin
                    n_res.status    = ast_pkg::ST_FULL;
                    n_res.slot_used = 4'd0;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ast_pkg::ENG_CHECK: begin
                // Reads are issued one slot ahead of the compare.
                if (w_hit) begin
                    n_slot_valid[r_cmp_idx] = 1'b0;
                    n_res.status            = ast_pkg::ST_FIRED;
                    n_res.slot_used         = 4'(r_cmp_idx);
                    n_res.alarm_fired       = 1'b1;
                end else if (r_pend && (r_cmp_idx == LAST)) begin
                    n_res.status    = ast_pkg::ST_NO_MATCH;
                    n_res.slot_used = 4'd0;
                end else begin
                    w_rd_en   = 1'b1;
                    n_cmp_idx = r_idx;
                    n_pend    = 1'b1;
                    if (r_idx != LAST) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            ast_pkg::ENG_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ast_pkg::ENG_IDLE;
            r_pend       <= 1'b0;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend       <= n_pend;
            r_slot_valid <= n_slot_valid;
            r_out_valid  <= n_out_valid;
        end
        r_job      <= n_job;
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

endmodule

`default_nettype wire

[hw/rtl/alarm_slot_table_core.sv]
// Top level of the alarm slot table: front end, job queue and sequencer.
`default_nettype none
`include "alarm_slot_table_core_defines.svh"

// The table holds SLOT_COUNT alarm times, each with a valid bit, and answers
// every command word with exactly one result word. A delete or an unused
// command needs no scan and is settled in the cycle the sequencer takes it
// up; an add walks the valid bits one slot a cycle; a check reads the time
// RAM one slot a cycle through its single registered read port. Each job
// also passes through the sequencer's idle and done states, and a word
// waits in the front register and queue while the previous job runs. All
// slots are free straight after reset; there is no clearing pass.
module alarm_slot_table_core #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire ast_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ast_pkg::t_out_word      o_out_word
);

    logic          w_push_valid;
    logic          w_push_ready;
    ast_pkg::t_job w_push_job;
    logic          w_pop_valid;
    logic          w_pop_ready;
    ast_pkg::t_job w_pop_job;

    // Accept and classify command words.
    ast_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_job        (w_push_job)
    );

    // Decouple the front end from the sequencer.
    ast_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_job    (w_pop_job)
    );

    // Carry out jobs against the slot table.
    ast_engine #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_pop_valid),
        .o_job_ready (w_pop_ready),
        .i_job       (w_pop_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // Only a fired check raises the alarm flag.
    `AST_ASSERT_IMPL(a_fired_flag, i_clk, i_rst_n,
        o_out_valid && (o_out_word.status != ast_pkg::ST_FIRED),
        !o_out_word.alarm_fired, "alarm flag raised without a fired status")

    // Full and no-match results carry slot zero.
    `AST_ASSERT_IMPL(a_zero_slot, i_clk, i_rst_n,
        o_out_valid && ((o_out_word.status == ast_pkg::ST_FULL)
            || (o_out_word.status == ast_pkg::ST_NO_MATCH)),
        o_out_word.slot_used == 4'd0, "full or no-match result names a slot")

    // A filled or fired slot always lies inside the table.
    `AST_ASSERT_IMPL(a_added_slot, i_clk, i_rst_n,
        o_out_valid && ((o_out_word.status == ast_pkg::ST_ADDED)
            || (o_out_word.status == ast_pkg::ST_FIRED)),
        (SLOT_COUNT > 16) || (int'(o_out_word.slot_used) < SLOT_COUNT),
        "filled or fired slot lies beyond the table")

    // Reset empties the pipeline on both sides.
    `AST_ASSERT_NEXT(a_reset_clears, i_clk, !i_rst_n,
        !o_out_valid && o_in_ready && !w_push_valid,
        "reset left a word in flight")

endmodule

`default_nettype wire
